// ----- rtl/b64d_pkg.sv -----
// shared types, constants and the alphabet lookup for the base64 stream decoder
package b64d_pkg;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SLASH_CHAR = 8'h2F;
    localparam int         RES_PER_JOB = 3;

    // one input request
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } t_in;

    // one result request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       bad_char;
        logic       run_last;
        logic       text_done;
    } t_out;

    // one result as built by the front end
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       bad_char;
    } t_res;

    // all results caused by one character
    typedef struct packed {
        t_res [RES_PER_JOB-1:0] res;
        logic [1:0]             count;
        logic                   eot;
    } t_job;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_stat;

    typedef struct packed {
        logic       hit;
        logic [5:0] value;
    } t_sextet;

    function automatic t_sextet sextet_of(input logic [7:0] ch);
        t_sextet s;
        s.hit   = 1'b1;
        s.value = 6'd0;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            s.value = 6'(ch - 8'h41);
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            s.value = 6'(ch - 8'h61 + 8'd26);
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            s.value = 6'(ch - 8'h30 + 8'd52);
        end else if (ch == PLUS_CHAR) begin
            s.value = 6'd62;
        end else if (ch == SLASH_CHAR) begin
            s.value = 6'd63;
        end else begin
            s.hit = 1'b0;
        end
        return s;
    endfunction

endpackage

// ----- rtl/b64d_front.sv -----
// front end: classifies each character, keeps the group state, builds a result job
module b64d_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  b64d_pkg::t_in i_data,
    output logic          o_push,
    output b64d_pkg::t_job o_job
);
    import b64d_pkg::*;

    logic [1:0]  r_phase, n_phase;
    logic [17:0] r_hold, n_hold;
    logic        r_pad, n_pad;

    t_sextet     sx;
    logic [23:0] full;
    t_job        job;
    logic [1:0]  cnt;

    always_comb begin
        sx      = sextet_of(i_data.char_code);
        full    = {r_hold, sx.value};
        n_phase = r_phase;
        n_hold  = r_hold;
        n_pad   = r_pad;
        job     = '0;
        cnt     = 2'd0;

        if (!r_pad) begin
            if (i_data.char_code == PAD_CHAR) begin
                if (r_phase == 2'd2) begin
                    job.res[cnt] = '{data_byte: r_hold[11:4], byte_valid: 1'b1, bad_char: 1'b0};
                    cnt = cnt + 2'd1;
                end else if (r_phase == 2'd3) begin
                    job.res[cnt] = '{data_byte: r_hold[17:10], byte_valid: 1'b1, bad_char: 1'b0};
                    cnt = cnt + 2'd1;
                    job.res[cnt] = '{data_byte: r_hold[9:2], byte_valid: 1'b1, bad_char: 1'b0};
                    cnt = cnt + 2'd1;
                end else begin
                    job.res[cnt] = '{data_byte: 8'd0, byte_valid: 1'b0, bad_char: 1'b1};
                    cnt = cnt + 2'd1;
                end
                n_pad   = 1'b1;
                n_phase = 2'd0;
                n_hold  = '0;
            end else if (!sx.hit) begin
                job.res[cnt] = '{data_byte: 8'd0, byte_valid: 1'b0, bad_char: 1'b1};
                cnt = cnt + 2'd1;
            end else if (r_phase == 2'd3) begin
                job.res[cnt] = '{data_byte: full[23:16], byte_valid: 1'b1, bad_char: 1'b0};
                cnt = cnt + 2'd1;
                job.res[cnt] = '{data_byte: full[15:8], byte_valid: 1'b1, bad_char: 1'b0};
                cnt = cnt + 2'd1;
                job.res[cnt] = '{data_byte: full[7:0], byte_valid: 1'b1, bad_char: 1'b0};
                cnt = cnt + 2'd1;
                n_phase = 2'd0;
                n_hold  = '0;
            end else begin
                n_hold  = {r_hold[11:0], sx.value};
                n_phase = r_phase + 2'd1;
            end
        end

        if (i_data.end_of_text) begin
            // flush an unpadded partial group
            if (!n_pad) begin
                if (n_phase == 2'd1) begin
                    job.res[cnt] = '{data_byte: 8'd0, byte_valid: 1'b0, bad_char: 1'b1};
                    cnt = cnt + 2'd1;
                end else if (n_phase == 2'd2) begin
                    job.res[cnt] = '{data_byte: n_hold[11:4], byte_valid: 1'b1, bad_char: 1'b0};
                    cnt = cnt + 2'd1;
                end else if (n_phase == 2'd3) begin
                    job.res[cnt] = '{data_byte: n_hold[17:10], byte_valid: 1'b1, bad_char: 1'b0};
                    cnt = cnt + 2'd1;
                    job.res[cnt] = '{data_byte: n_hold[9:2], byte_valid: 1'b1, bad_char: 1'b0};
                    cnt = cnt + 2'd1;
                end
            end
            // end of text always yields at least one result
            if (cnt == 2'd0) begin
                cnt = 2'd1;
            end
            n_phase = 2'd0;
            n_hold  = '0;
            n_pad   = 1'b0;
        end

        job.count = cnt;
        job.eot   = i_data.end_of_text;
    end

    assign o_push = i_accept && (cnt != 2'd0);
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_hold  <= '0;
            r_pad   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_hold  <= n_hold;
            r_pad   <= n_pad;
        end
    end

endmodule

// ----- rtl/b64d_fifo.sv -----
// short job queue between front end and back end
module b64d_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b64d_pkg::t_job    i_job,
    input  logic              i_pop,
    output b64d_pkg::t_q_stat o_stat,
    output b64d_pkg::t_job    o_head
);
    import b64d_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_stat.not_empty = (r_count != '0);
    assign o_stat.full      = (r_count == CW'(DEPTH));
    assign o_head           = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/b64d_back.sv -----
// back end: walks the results of the head job into the output register
module b64d_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  b64d_pkg::t_q_stat i_stat,
    input  b64d_pkg::t_job    i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output b64d_pkg::t_out    o_data
);
    import b64d_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    t_out       r_out;
    t_res       cur;
    logic       load, take, last;

    assign load = !r_valid || i_ready;
    assign take = load && i_stat.not_empty;
    assign cur  = i_head.res[r_idx];
    assign last = (r_idx == i_head.count - 2'd1);

    assign o_pop   = take && last;
    assign o_valid = r_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out.data_byte  <= cur.data_byte;
            r_out.byte_valid <= cur.byte_valid;
            r_out.bad_char   <= cur.bad_char;
            r_out.run_last   <= last;
            r_out.text_done  <= last && i_head.eot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= i_stat.not_empty;
            end
            if (take) begin
                r_idx <= last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

endmodule

// ----- rtl/base64_stream_decoder.sv -----
// top level of the base64 stream decoder: front end, job queue, back end
// a character's job is queued, and its results leave through the output register
// throughput: one character per cycle in unless the queue is full, one result per cycle
//   out while i_ready is high; a full group's three results drain from the job queue
// input ready drops only while the job queue (DEPTH jobs) is full
// reset (synchronous, active low) clears the group state, the queue and the output valid
module base64_stream_decoder #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  b64d_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output b64d_pkg::t_out o_data
);
    import b64d_pkg::*;

    // handshake between the sides
    logic    accept;
    logic    push;
    logic    pop;
    t_job    push_job;
    t_job    head_job;
    t_q_stat q_stat;

    // a character is taken whenever the queue has room for its job
    assign o_ready = !q_stat.full;
    assign accept  = i_valid && o_ready;

    // classify the character and update the group state at once
    b64d_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (i_data),
        .o_push   (push),
        .o_job    (push_job)
    );

    // jobs wait here while the output side is stalled
    b64d_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_stat  (q_stat),
        .o_head  (head_job)
    );

    // one result request per cycle out of the head job while the receiver is ready
    b64d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (q_stat),
        .i_head  (head_job),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // end of text always closes the run of its character
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.text_done) |-> o_data.run_last)
        else $error("text_done without run_last");

    // a result is never both a byte and a bad character
    a_byte_or_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.byte_valid && o_data.bad_char))
        else $error("byte_valid and bad_char together");

    // results without a byte carry zero data
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.byte_valid) |-> (o_data.data_byte == 8'd0))
        else $error("nonzero data on a result without a byte");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

// ----- verif/base64_stream_decoder_test.sv -----
// self-checking testbench for the base64 stream decoder with its result scoreboard
class b64_decode_ledger;

    b64d_pkg::t_out owed[$];
    b64d_pkg::t_out batch[$];
    int             mismatches;

    bit [1:0]  phase;
    bit [17:0] hold;
    bit        pad_seen;

    function new();
        mismatches = 0;
        clear_group();
    endfunction

    function void clear_group();
        phase    = '0;
        hold     = '0;
        pad_seen = 1'b0;
    endfunction

    function int pending();
        return owed.size();
    endfunction

    // standard alphabet, -1 for anything outside it
    function int sextet_value(bit [7:0] ch);
        if (ch >= "A" && ch <= "Z") return ch - "A";
        if (ch >= "a" && ch <= "z") return ch - "a" + 26;
        if (ch >= "0" && ch <= "9") return ch - "0" + 52;
        if (ch == b64d_pkg::PLUS_CHAR) return 62;
        if (ch == b64d_pkg::SLASH_CHAR) return 63;
        return -1;
    endfunction

    function void add(bit [7:0] data, bit valid, bit bad);
        b64d_pkg::t_out r;
        r.data_byte  = valid ? data : 8'h00;
        r.byte_valid = valid;
        r.bad_char   = bad;
        r.run_last   = 1'b0;
        r.text_done  = 1'b0;
        batch = {batch, r};
    endfunction

    // partial tail of two or three sextets, at padding or at end of text
    function void flush_tail();
        if (phase == 2'd2) begin
            add(hold[11:4], 1'b1, 1'b0);
        end else if (phase == 2'd3) begin
            add(hold[17:10], 1'b1, 1'b0);
            add(hold[9:2], 1'b1, 1'b0);
        end
    endfunction

    // predicts the results of one accepted character request
    function void note_char(b64d_pkg::t_in req);
        int        s;
        bit [23:0] full;
        batch.delete();
        if (!pad_seen) begin
            s = sextet_value(req.char_code);
            if (req.char_code == b64d_pkg::PAD_CHAR) begin
                if (phase >= 2'd2) flush_tail();
                else add(8'h00, 1'b0, 1'b1);
                pad_seen = 1'b1;
                phase    = '0;
                hold     = '0;
            end else if (s < 0) begin
                add(8'h00, 1'b0, 1'b1);
            end else if (phase == 2'd3) begin
                full = {hold, 6'(s)};
                add(full[23:16], 1'b1, 1'b0);
                add(full[15:8], 1'b1, 1'b0);
                add(full[7:0], 1'b1, 1'b0);
                phase = '0;
                hold  = '0;
            end else begin
                hold  = {hold[11:0], 6'(s)};
                phase = phase + 2'd1;
            end
        end
        if (req.end_of_text) begin
            if (!pad_seen) begin
                if (phase == 2'd1) add(8'h00, 1'b0, 1'b1);
                else flush_tail();
            end
            if (batch.size() == 0) add(8'h00, 1'b0, 1'b0);
            batch[$].text_done = 1'b1;
            clear_group();
        end
        if (batch.size() > 0) batch[$].run_last = 1'b1;
        owed = {owed, batch};
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // compares one accepted result request with the oldest prediction
    function void check_output(b64d_pkg::t_out got);
        b64d_pkg::t_out want;
        if (owed.size() == 0) begin
            $error("unexpected result: data_byte %0h byte_valid %0b bad_char %0b",
                   got.data_byte, got.byte_valid, got.bad_char);
            mismatches++;
            return;
        end
        want = owed.pop_front();
        check_field("data_byte", want.data_byte, got.data_byte);
        check_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
        check_field("bad_char", 8'(want.bad_char), 8'(got.bad_char));
        check_field("run_last", 8'(want.run_last), 8'(got.run_last));
        check_field("text_done", 8'(want.text_done), 8'(got.text_done));
    endfunction

    function void report_leftover();
        if (owed.size() != 0) begin
            $error("%0d predicted results never arrived", owed.size());
            mismatches++;
        end
    endfunction

endclass

module base64_stream_decoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    import b64d_pkg::*;

    // quiet cycles allowed before the run is declared hung; the longest correct
    // quiet stretch is a sender gap, a receiver stall or the tail wait
    localparam int STALL_LIMIT  = 400;
    localparam int RANDOM_CHARS = 74;
    localparam int TAIL_CYCLES  = 24;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_in  i_data  = '0;
    logic o_ready;
    logic o_valid;
    t_out o_data;

    b64_decode_ledger ledger = new();

    // idle modes, flipped now and then to get runs with no gaps at all
    bit steady_in  = 1'b0;
    bit steady_out = 1'b0;
    int chars_sent = 0;

    base64_stream_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // 12 ns clock
    always begin
        #6ns i_clk = 1'b1;
        #6ns i_clk = 1'b0;
    end

    // gap before a request: zero a third of the time, else a uniform draw that may also be zero
    function automatic int draw_gap();
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 17);
    endfunction

    // maps a sextet value back to its character
    function automatic bit [7:0] alpha_char(int idx);
        if (idx < 26) return 8'("A" + idx);
        if (idx < 52) return 8'("a" + idx - 26);
        if (idx < 62) return 8'("0" + idx - 52);
        if (idx == 62) return PLUS_CHAR;
        return SLASH_CHAR;
    endfunction

    function automatic bit [7:0] rand_alpha();
        return alpha_char($urandom_range(0, 63));
    endfunction

    // one character request; valid stays high across back-to-back requests
    task automatic send_char(bit [7:0] ch, bit eot);
        int gap;
        gap = steady_in ? 0 : draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{char_code: ch, end_of_text: eot};
        do @(posedge i_clk); while (!o_ready);
        ledger.note_char(i_data);
        chars_sent++;
    endtask

    // a string of characters, end of text on the last one if asked
    task automatic send_text(string s, bit eot_last);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], eot_last && (i == s.len() - 1));
        end
    endtask

    // hold off the sender until every predicted result has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (ledger.pending() != 0);
    endtask

    // mostly well-formed text with random content, plus noise and run-on texts
    task automatic send_random_text();
        bit [7:0] text[$];
        int       groups;
        int       tail;
        int       ending;
        bit       eot_last;
        groups = $urandom_range(0, 3);
        for (int i = 0; i < groups * 4; i++) text = {text, rand_alpha()};
        tail = $urandom_range(0, 5);
        if (tail >= 1 && tail <= 3) begin
            // unpadded tail, flushed or cut off at end of text
            repeat (tail) text = {text, rand_alpha()};
        end else if (tail == 4) begin
            repeat (2) text = {text, rand_alpha()};
            text = {text, PAD_CHAR};
            text = {text, PAD_CHAR};
        end else if (tail == 5) begin
            repeat (3) text = {text, rand_alpha()};
            text = {text, PAD_CHAR};
        end
        // junk after the text, ignored once padding was seen
        if ($urandom_range(0, 3) == 0) text = {text, 8'($urandom_range(0, 255))};
        if (text.size() == 0) text = {text, rand_alpha()};
        ending   = $urandom_range(0, 9);
        eot_last = (ending < 7);
        foreach (text[i]) begin
            // stray byte, anything in 0..255, now and then
            if ($urandom_range(0, 9) == 0) send_char(8'($urandom_range(0, 255)), 1'b0);
            send_char(text[i], eot_last && (i == text.size() - 1));
        end
        // end of text on an extra character; ending 9 runs on into the next text
        if (ending == 7) send_char(8'($urandom_range(0, 255)), 1'b1);
        if (ending == 8) send_char(PAD_CHAR, 1'b1);
    endtask

    // receiver: random stall per result, with stretches of steady ready
    initial begin : result_sink
        int gap;
        wait (i_rst_n);
        forever begin
            gap = steady_out ? 0 : draw_gap();
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            if ($urandom_range(0, 15) == 0) steady_out = !steady_out;
        end
    end

    // every accepted result request goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            ledger.check_output(o_data);
        end
    end

    // watchdog on cycles in which neither side moves a request
    initial begin : stall_watch
        int quiet;
        quiet = 0;
        wait (i_rst_n);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet = 0;
            else quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        int texts;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // alphabet extremes in two full groups, end of text on a full group
        send_text("AZaz", 1'b0);
        send_text("09+/", 1'b1);
        // padding in position 3, second pad ignored, end of text alone
        send_text("QQ==", 1'b1);
        // padding in position 4 with end of text on it
        send_text("QUI=", 1'b1);
        // bad characters at both ends of the code range, end of text cuts a group
        send_char("Q", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        // three sextets flushed without padding
        send_text("QUI", 1'b1);
        // padding in position 2, then a bad character ignored after it
        send_text("A=*", 1'b1);
        // padding in position 1 together with end of text
        send_char(PAD_CHAR, 1'b1);

        // sender pauses until the decoder has drained
        wait_drained();

        texts = 0;
        while (chars_sent < 26 + RANDOM_CHARS) begin
            if ($urandom_range(0, 3) == 0) steady_in = !steady_in;
            send_random_text();
            texts++;
            if (texts == 10) wait_drained();
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (ledger.pending() != 0);
        // let any stray extra result show up
        repeat (TAIL_CYCLES) @(posedge i_clk);
        ledger.report_leftover();
        if (ledger.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/b64d_pkg.sv
rtl/b64d_front.sv
rtl/b64d_fifo.sv
rtl/b64d_back.sv
rtl/base64_stream_decoder.sv
verif/base64_stream_decoder_test.sv
